// ===== rtl/core/swgf_pkg.sv =====
`timescale 1ns / 1ps
// swgf_pkg: widths, constants and shared types of the soft-wall and gravity force unit
// no dependencies; imported by every module of the unit

package swgf_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;

    // field widths
    localparam int POS_W     = 32;
    localparam int BOX_W     = 31;
    localparam int GRAV_W    = 32;
    localparam int FORCE_W   = 48;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // penetration: position minus a border, two guard bits
    localparam int PEN_W   = POS_W + 2;
    // beyond 2^PEN_EXP (real units) the sixth-power term always hits the cap
    localparam int PEN_EXP = (FRAC_BITS >= 12) ? 5 : 6;
    localparam int P_W     = FRAC_BITS + PEN_EXP;
    // q after five steps stays below 2^(F + 6 * PEN_EXP)
    localparam int Q_W     = FRAC_BITS + 6 * PEN_EXP;
    localparam int PR_W    = Q_W + P_W;
    localparam int POW_STEPS = 5;

    // wall term: 500 * q, capped at 2^49
    localparam int TERM_W = 50;
    localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};
    localparam int WALL_K = 500;
    localparam int SC_W   = (Q_W + 9 > TERM_W + 1) ? Q_W + 9 : TERM_W + 1;

    // force accumulation
    localparam int FG_W  = FORCE_W + 1;
    localparam int SUM_W = TERM_W + 2;
    localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    // borders: lower at 2.0, upper at box - 1.0 - 2.0
    localparam logic [PEN_W-1:0] PEN_TWO   = PEN_W'(2) << FRAC_BITS;
    localparam logic [PEN_W-1:0] PEN_THREE = PEN_W'(3) << FRAC_BITS;

    // register reset: box of 64.0
    localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(64) << FRAC_BITS;

    // request to result: front stage, power chain, scale, sum, output
    localparam int LAT = POW_STEPS + 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_X  = 3'd0,
        CFG_BOX_Y  = 3'd1,
        CFG_BOX_Z  = 3'd2,
        CFG_GRAV_X = 3'd3,
        CFG_GRAV_Y = 3'd4,
        CFG_GRAV_Z = 3'd5
    } t_cfg_idx;

    // one wall's penetration as handed to the power chain
    typedef struct packed {
        logic [P_W-1:0] p;    // zero when the wall is not touched
        logic           big;  // penetration past the cap threshold
    } t_pen;

endpackage

// ===== rtl/core/swgf_pow.sv =====
`timescale 1ns / 1ps
// swgf_pow: pipelined 500 * p^6 with truncation after each step and a cap
// depends on swgf_pkg

module swgf_pow (
    input  logic                          i_clk,
    input  swgf_pkg::t_pen                i_pen,
    output logic [swgf_pkg::TERM_W-1:0]   o_term
);
    import swgf_pkg::*;

    logic [Q_W-1:0]  c_q    [POW_STEPS];
    logic [P_W-1:0]  c_p    [POW_STEPS];
    logic            c_b    [POW_STEPS];
    logic [PR_W-1:0] c_prod [POW_STEPS];
    logic [Q_W-1:0]  r_q    [POW_STEPS];
    logic [P_W-1:0]  r_p    [POW_STEPS-1];
    logic            r_b    [POW_STEPS];

    logic [SC_W-1:0]   scaled;
    logic [TERM_W-1:0] n_term;
    logic [TERM_W-1:0] r_term;

    for (genvar k = 0; k < POW_STEPS; k++) begin : g_step
        if (k == 0) begin : g_first
            assign c_q[k] = Q_W'(i_pen.p);
            assign c_p[k] = i_pen.p;
            assign c_b[k] = i_pen.big;
        end else begin : g_next
            assign c_q[k] = r_q[k-1];
            assign c_p[k] = r_p[k-1];
            assign c_b[k] = r_b[k-1];
        end

        // q * p, drop the fraction bits
        assign c_prod[k] = PR_W'(c_q[k]) * PR_W'(c_p[k]);

        always_ff @(posedge i_clk) begin
            r_q[k] <= c_prod[k][FRAC_BITS +: Q_W];
            r_b[k] <= c_b[k];
        end

        if (k < POW_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_p[k] <= c_p[k];
            end
        end
    end

    // scale by the wall constant and clamp to the cap
    always_comb begin
        scaled = SC_W'(r_q[POW_STEPS-1]) * SC_W'(WALL_K);
        if (r_b[POW_STEPS-1] || scaled > SC_W'(TERM_CAP)) begin
            n_term = TERM_CAP;
        end else begin
            n_term = scaled[TERM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
    end

    assign o_term = r_term;

endmodule

// ===== rtl/core/swgf_axis.sv =====
`timescale 1ns / 1ps
// swgf_axis: one axis: penetration front stage, two wall power chains, sum and clamp
// depends on swgf_pkg and swgf_pow

module swgf_axis (
    input  logic                                 i_clk,
    input  logic signed [swgf_pkg::POS_W-1:0]    i_pos,
    input  logic signed [swgf_pkg::FORCE_W-1:0]  i_force,
    input  logic        [swgf_pkg::BOX_W-1:0]    i_box,
    input  logic signed [swgf_pkg::GRAV_W-1:0]   i_grav,
    output logic signed [swgf_pkg::FORCE_W-1:0]  o_force,
    output logic                                 o_sat
);
    import swgf_pkg::*;

    // positive penetration to power-chain operand
    function automatic t_pen make_pen(input logic [PEN_W-1:0] pen);
        t_pen res;
        logic act;
        act     = !pen[PEN_W-1] && (pen != '0);
        res.big = act && (pen[PEN_W-2:P_W] != '0);
        res.p   = (act && !res.big) ? pen[P_W-1:0] : '0;
        return res;
    endfunction

    logic [PEN_W-1:0] pos_e;
    logic [PEN_W-1:0] box_e;
    logic [PEN_W-1:0] pen_lo;
    logic [PEN_W-1:0] pen_hi;
    logic signed [FG_W-1:0] n_fg;

    t_pen r_pen_lo;
    t_pen r_pen_hi;
    logic signed [FG_W-1:0] r_fg [POW_STEPS+2];

    logic [TERM_W-1:0] term_lo;
    logic [TERM_W-1:0] term_hi;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] r_sum;
    logic ovf_hi;
    logic ovf_lo;

    always_comb begin
        pos_e  = {{(PEN_W-POS_W){i_pos[POS_W-1]}}, i_pos};
        box_e  = {{(PEN_W-BOX_W){1'b0}}, i_box};
        pen_lo = PEN_TWO - pos_e;
        pen_hi = pos_e - box_e + PEN_THREE;
        n_fg   = FG_W'(i_force) + FG_W'(i_grav);
    end

    always_ff @(posedge i_clk) begin
        r_pen_lo <= make_pen(pen_lo);
        r_pen_hi <= make_pen(pen_hi);
        r_fg[0]  <= n_fg;
        for (int k = 1; k < POW_STEPS + 2; k++) begin
            r_fg[k] <= r_fg[k-1];
        end
    end

    swgf_pow u_pow_lo (
        .i_clk  (i_clk),
        .i_pen  (r_pen_lo),
        .o_term (term_lo)
    );

    swgf_pow u_pow_hi (
        .i_clk  (i_clk),
        .i_pen  (r_pen_hi),
        .o_term (term_hi)
    );

    // lower wall pushes up, upper wall pushes down
    always_comb begin
        n_sum = SUM_W'(r_fg[POW_STEPS+1])
              + SUM_W'(signed'({1'b0, term_lo}))
              - SUM_W'(signed'({1'b0, term_hi}));
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    always_comb begin
        ovf_hi = !r_sum[SUM_W-1] && (r_sum[SUM_W-2:FORCE_W-1] != '0);
        ovf_lo = r_sum[SUM_W-1] && !(&r_sum[SUM_W-2:FORCE_W-1]);
        if (ovf_hi) begin
            o_force = FORCE_MAX;
        end else if (ovf_lo) begin
            o_force = FORCE_MIN;
        end else begin
            o_force = r_sum[FORCE_W-1:0];
        end
        o_sat = ovf_hi || ovf_lo;
    end

endmodule

// ===== rtl/core/soft_wall_gravity_force_unit.sv =====
`timescale 1ns / 1ps
// soft_wall_gravity_force_unit: top level, config registers, valid pipe, three axis lanes
// depends on swgf_pkg and swgf_axis (which uses swgf_pow)
//
//   channel   direction  handshake               payload
//   request   in         start, busy             i_pos_x/y/z, i_force_in_x/y/z
//   result    out        o_done (one cycle)      o_force_out_x/y/z, o_saturated
//   config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// a request is taken on every edge with start high and busy low; one request per cycle
// the result strobes o_done after the request has passed one penetration stage,
// five multiply stages and one scale stage per wall, one sum stage and one output register
// busy is high only during reset and the cycle after it; no clearing pass
// the receiver cannot stall, so the pipeline never holds and nothing waits in a skid stage
// config writes take effect on the next edge; write only while no request is in flight

module soft_wall_gravity_force_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_we,
    input  logic        [swgf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [swgf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic signed [swgf_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [swgf_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [swgf_pkg::POS_W-1:0]      i_pos_z,
    input  logic signed [swgf_pkg::FORCE_W-1:0]    i_force_in_x,
    input  logic signed [swgf_pkg::FORCE_W-1:0]    i_force_in_y,
    input  logic signed [swgf_pkg::FORCE_W-1:0]    i_force_in_z,
    output logic                                   o_done,
    output logic signed [swgf_pkg::FORCE_W-1:0]    o_force_out_x,
    output logic signed [swgf_pkg::FORCE_W-1:0]    o_force_out_y,
    output logic signed [swgf_pkg::FORCE_W-1:0]    o_force_out_z,
    output logic                                   o_saturated
);
    import swgf_pkg::*;

    // config registers
    logic        [BOX_W-1:0]  r_box_x, r_box_y, r_box_z;
    logic signed [GRAV_W-1:0] r_grav_x, r_grav_y, r_grav_z;

    // control
    logic           r_up;
    logic [LAT-1:0] r_vld;
    logic           accept;

    // lane results and output registers
    logic signed [FORCE_W-1:0] ax_force_x, ax_force_y, ax_force_z;
    logic                      ax_sat_x, ax_sat_y, ax_sat_z;
    logic signed [FORCE_W-1:0] r_fx, r_fy, r_fz;
    logic                      r_sat;

    assign busy   = !r_up;
    assign accept = start && !busy;

    // config write port, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x  <= BOX_RESET;
            r_box_y  <= BOX_RESET;
            r_box_z  <= BOX_RESET;
            r_grav_x <= '0;
            r_grav_y <= '0;
            r_grav_z <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BOX_X:  r_box_x  <= i_cfg_data[BOX_W-1:0];
                CFG_BOX_Y:  r_box_y  <= i_cfg_data[BOX_W-1:0];
                CFG_BOX_Z:  r_box_z  <= i_cfg_data[BOX_W-1:0];
                CFG_GRAV_X: r_grav_x <= i_cfg_data[GRAV_W-1:0];
                CFG_GRAV_Y: r_grav_y <= i_cfg_data[GRAV_W-1:0];
                CFG_GRAV_Z: r_grav_z <= i_cfg_data[GRAV_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits ride alongside the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up  <= 1'b0;
            r_vld <= '0;
        end else begin
            r_up  <= 1'b1;
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // three identical lanes, one per axis
    swgf_axis u_axis_x (
        .i_clk   (i_clk),
        .i_pos   (i_pos_x),
        .i_force (i_force_in_x),
        .i_box   (r_box_x),
        .i_grav  (r_grav_x),
        .o_force (ax_force_x),
        .o_sat   (ax_sat_x)
    );

    swgf_axis u_axis_y (
        .i_clk   (i_clk),
        .i_pos   (i_pos_y),
        .i_force (i_force_in_y),
        .i_box   (r_box_y),
        .i_grav  (r_grav_y),
        .o_force (ax_force_y),
        .o_sat   (ax_sat_y)
    );

    swgf_axis u_axis_z (
        .i_clk   (i_clk),
        .i_pos   (i_pos_z),
        .i_force (i_force_in_z),
        .i_box   (r_box_z),
        .i_grav  (r_grav_z),
        .o_force (ax_force_z),
        .o_sat   (ax_sat_z)
    );

    // output register, payload needs no reset
    always_ff @(posedge i_clk) begin
        r_fx  <= ax_force_x;
        r_fy  <= ax_force_y;
        r_fz  <= ax_force_z;
        r_sat <= ax_sat_x || ax_sat_y || ax_sat_z;
    end

    assign o_done        = r_vld[LAT-1];
    assign o_force_out_x = r_fx;
    assign o_force_out_y = r_fy;
    assign o_force_out_z = r_fz;
    assign o_saturated   = r_sat;

`ifndef ASSERT_OFF
    // every accepted request comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("request did not produce a result after the pipeline latency");

    // no result without a request the full latency earlier
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result strobe without a matching request");

    // busy drops once reset has been released and sampled high into r_up
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy still high after reset release");

    // a saturated result has at least one axis at a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |->
            (o_force_out_x == FORCE_MAX || o_force_out_x == FORCE_MIN ||
             o_force_out_y == FORCE_MAX || o_force_out_y == FORCE_MIN ||
             o_force_out_z == FORCE_MAX || o_force_out_z == FORCE_MIN))
        else $error("saturation flag set with no axis at a limit");
`endif

endmodule
